[rtl/core/lfd_pkg.sv]
// Shared widths, register indexes and types of the line follow drive block.
package lfd_pkg;

	localparam int SENSOR_LANES = 5;
	localparam int THR_W = 12;
	localparam int SPD_W = 10;
	localparam int LIM_W = 11;
	localparam int CNT_W = 3;
	localparam int RUN_W = 16;
	localparam int POS_W = 12;
	localparam int CFG_DW = 16;
	localparam int CFG_IW = 3;

	localparam logic [CFG_IW-1:0] REG_BLACK_THRESHOLD = 3'd0;
	localparam logic [CFG_IW-1:0] REG_STRAIGHT_SPEED = 3'd1;
	localparam logic [CFG_IW-1:0] REG_CURVE_SPEED = 3'd2;
	localparam logic [CFG_IW-1:0] REG_CURVE_LIMIT = 3'd3;
	localparam logic [CFG_IW-1:0] REG_MAX_SPEED = 3'd4;
	localparam logic [CFG_IW-1:0] REG_CROSSING_COUNT = 3'd5;
	localparam logic [CFG_IW-1:0] REG_CLEAR_RUN = 3'd6;

	typedef struct packed {
		logic [SPD_W-1:0] left;
		logic [SPD_W-1:0] right;
	} speed_pair_t;

	typedef struct packed {
		logic [SPD_W-1:0] cruise_speed;
		logic [CNT_W-1:0] crossing_count;
		logic [RUN_W-1:0] clear_run;
	} mode_cfg_t;

endpackage

[rtl/core/lfd_lane.sv]
// One sensor lane: compares a reading against the black threshold.
module lfd_lane import lfd_pkg::*; #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic [SAMPLE_BITS-1:0] reading,
	input  logic [THR_W-1:0]       threshold,
	output logic                   hit_s1
);

	localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

	logic [CMP_W-1:0] reading_ext;
	logic [CMP_W-1:0] threshold_ext;

	assign reading_ext = CMP_W'(reading);
	assign threshold_ext = CMP_W'(threshold);

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s1 <= reading_ext > threshold_ext;
		end
	end

endmodule

[rtl/core/lfd_steer.sv]
// Follow-mode steering: base speed choice, half-position correction and clamping.
module lfd_steer import lfd_pkg::*; (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [POS_W-1:0] position,
	input  logic [SPD_W-1:0]        cruise_speed,
	input  logic [SPD_W-1:0]        bend_speed,
	input  logic [LIM_W-1:0]        curve_limit,
	input  logic [SPD_W-1:0]        max_speed,
	output speed_pair_t             follow_s1
);

	localparam int SUM_W = POS_W + 1;

	logic [POS_W-1:0]        mag;
	logic signed [POS_W-1:0] corr;
	logic [SPD_W-1:0]        base;
	logic signed [SUM_W-1:0] base_ext;
	logic signed [SUM_W-1:0] corr_ext;
	logic signed [SUM_W-1:0] left_sum;
	logic signed [SUM_W-1:0] right_sum;

	function automatic logic [SPD_W-1:0] clamp_speed(input logic signed [SUM_W-1:0] v,
			input logic [SPD_W-1:0] limit);
		logic [SPD_W-1:0] res;
		if (v[SUM_W-1]) begin
			res = '0;
		end else if (v[SUM_W-2:0] > (SUM_W-1)'(limit)) begin
			res = limit;
		end else begin
			res = v[SPD_W-1:0];
		end
		return res;
	endfunction

	assign mag = position[POS_W-1] ? POS_W'(-position) : POS_W'(position);
	assign base = (mag > POS_W'(curve_limit)) ? bend_speed : cruise_speed;
	// Adding the sign bit before the shift truncates negative halves toward zero.
	assign corr = (position + $signed({{(POS_W-1){1'b0}}, position[POS_W-1]})) >>> 1;
	assign base_ext = $signed(SUM_W'(base));
	assign corr_ext = SUM_W'(corr);
	assign left_sum = base_ext + corr_ext;
	assign right_sum = base_ext - corr_ext;

	always_ff @(posedge clk) begin
		if (en) begin
			follow_s1.left <= clamp_speed(left_sum, max_speed);
			follow_s1.right <= clamp_speed(right_sum, max_speed);
		end
	end

endmodule

[rtl/core/lfd_mode.sv]
// Merges the lane hits into a count, runs the crossing mode and holds the result item.
module lfd_mode import lfd_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  logic                    item_s1,
	input  logic [SENSOR_LANES-1:0] hit_s1,
	input  speed_pair_t             follow_s1,
	input  mode_cfg_t               cfg,
	output logic                    out_valid,
	output logic [SPD_W-1:0]        left_speed,
	output logic [SPD_W-1:0]        right_speed,
	output logic                    in_crossing,
	output logic [CNT_W-1:0]        black_count
);

	logic             crossing_q;
	logic [RUN_W-1:0] clear_cnt_q;
	logic [CNT_W-1:0] count;
	logic             wide;
	logic             drive_cross;
	logic [RUN_W:0]   clear_inc;
	logic             crossing_nxt;
	logic [RUN_W-1:0] clear_cnt_nxt;

	always_comb begin
		count = '0;
		for (int i = 0; i < SENSOR_LANES; i++) begin
			count = count + CNT_W'(hit_s1[i]);
		end
	end

	assign wide = count >= cfg.crossing_count;
	assign drive_cross = crossing_q || wide;
	assign clear_inc = (RUN_W+1)'(clear_cnt_q) + (RUN_W+1)'(1);

	always_comb begin
		crossing_nxt = crossing_q;
		clear_cnt_nxt = clear_cnt_q;
		if (drive_cross) begin
			if (wide) begin
				crossing_nxt = 1'b1;
				clear_cnt_nxt = '0;
			end else if (clear_inc >= (RUN_W+1)'(cfg.clear_run)) begin
				crossing_nxt = 1'b0;
				clear_cnt_nxt = '0;
			end else begin
				clear_cnt_nxt = clear_inc[RUN_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crossing_q <= 1'b0;
			clear_cnt_q <= '0;
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= item_s1;
			if (item_s1) begin
				crossing_q <= crossing_nxt;
				clear_cnt_q <= clear_cnt_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && item_s1) begin
			left_speed <= drive_cross ? cfg.cruise_speed : follow_s1.left;
			right_speed <= drive_cross ? cfg.cruise_speed : follow_s1.right;
			in_crossing <= drive_cross;
			black_count <= count;
		end
	end

endmodule

[rtl/core/line_follow_drive_with_crossing_hold_top.sv]
// Top level of the line follow drive with crossing hold.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    reading_0..reading_4, position
//   out      output     out_valid / out_ready  left_speed, right_speed, in_crossing,
//                                              black_count
//   cfg      input      cfg_wr_en              cfg_index, cfg_data
//
// An item passes two register stages, the first stage and then the output registers.
// The first stage compares the five lanes and computes the follow-mode speeds, the
// second counts the hits, updates the crossing mode and holds the result. One item is
// accepted every cycle while the output is not stalled. Reset clears both stage
// valid bits and the crossing state and loads the register defaults. A stalled
// output holds its item; the first stage keeps accepting until it is full as well.
module line_follow_drive_with_crossing_hold_top import lfd_pkg::*; #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [SAMPLE_BITS-1:0]  reading_0,
	input  logic [SAMPLE_BITS-1:0]  reading_1,
	input  logic [SAMPLE_BITS-1:0]  reading_2,
	input  logic [SAMPLE_BITS-1:0]  reading_3,
	input  logic [SAMPLE_BITS-1:0]  reading_4,
	input  logic signed [POS_W-1:0] position,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [SPD_W-1:0]        left_speed,
	output logic [SPD_W-1:0]        right_speed,
	output logic                    in_crossing,
	output logic [CNT_W-1:0]        black_count,
	input  logic                    cfg_wr_en,
	input  logic [CFG_IW-1:0]       cfg_index,
	input  logic [CFG_DW-1:0]       cfg_data
);

	logic [THR_W-1:0] black_threshold_q;
	logic [SPD_W-1:0] cruise_speed_q;
	logic [SPD_W-1:0] bend_speed_q;
	logic [LIM_W-1:0] curve_limit_q;
	logic [SPD_W-1:0] max_speed_q;
	logic [CNT_W-1:0] crossing_count_q;
	logic [RUN_W-1:0] clear_run_q;

	logic                    item_s1;
	logic                    load_s2;
	logic                    load_s1;
	logic [SAMPLE_BITS-1:0]  readings [SENSOR_LANES];
	logic [SENSOR_LANES-1:0] hit_s1;
	speed_pair_t             follow_s1;
	mode_cfg_t               mode_cfg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			black_threshold_q <= THR_W'(2000);
			cruise_speed_q <= SPD_W'(300);
			bend_speed_q <= SPD_W'(150);
			curve_limit_q <= LIM_W'(120);
			max_speed_q <= SPD_W'(600);
			crossing_count_q <= CNT_W'(3);
			clear_run_q <= RUN_W'(300);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_BLACK_THRESHOLD: black_threshold_q <= cfg_data[THR_W-1:0];
				REG_STRAIGHT_SPEED: cruise_speed_q <= cfg_data[SPD_W-1:0];
				REG_CURVE_SPEED: bend_speed_q <= cfg_data[SPD_W-1:0];
				REG_CURVE_LIMIT: curve_limit_q <= cfg_data[LIM_W-1:0];
				REG_MAX_SPEED: max_speed_q <= cfg_data[SPD_W-1:0];
				REG_CROSSING_COUNT: crossing_count_q <= cfg_data[CNT_W-1:0];
				REG_CLEAR_RUN: clear_run_q <= cfg_data[RUN_W-1:0];
				default: ;
			endcase
		end
	end

	assign load_s2 = !out_valid || out_ready;
	assign load_s1 = !item_s1 || load_s2;
	assign in_ready = load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= 1'b0;
		end else if (load_s1) begin
			item_s1 <= in_valid;
		end
	end

	assign readings[0] = reading_0;
	assign readings[1] = reading_1;
	assign readings[2] = reading_2;
	assign readings[3] = reading_3;
	assign readings[4] = reading_4;

	for (genvar g = 0; g < SENSOR_LANES; g++) begin : g_lane
		lfd_lane #(
			.SAMPLE_BITS(SAMPLE_BITS)
		) u_lane (
			.clk      (clk),
			.en       (load_s1 && in_valid),
			.reading  (readings[g]),
			.threshold(black_threshold_q),
			.hit_s1   (hit_s1[g])
		);
	end

	lfd_steer u_steer (
		.clk         (clk),
		.en          (load_s1 && in_valid),
		.position    (position),
		.cruise_speed(cruise_speed_q),
		.bend_speed  (bend_speed_q),
		.curve_limit (curve_limit_q),
		.max_speed   (max_speed_q),
		.follow_s1   (follow_s1)
	);

	assign mode_cfg.cruise_speed = cruise_speed_q;
	assign mode_cfg.crossing_count = crossing_count_q;
	assign mode_cfg.clear_run = clear_run_q;

	lfd_mode u_mode (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load_s2),
		.item_s1    (item_s1),
		.hit_s1     (hit_s1),
		.follow_s1  (follow_s1),
		.cfg        (mode_cfg),
		.out_valid  (out_valid),
		.left_speed (left_speed),
		.right_speed(right_speed),
		.in_crossing(in_crossing),
		.black_count(black_count)
	);

	a_cross_straight: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_crossing |-> left_speed == cruise_speed_q &&
			right_speed == cruise_speed_q)
		else $error("crossing item not driven straight");

	a_follow_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !in_crossing |-> left_speed <= max_speed_q &&
			right_speed <= max_speed_q)
		else $error("follow item speed above clamp");

	a_follow_narrow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !in_crossing |-> black_count < crossing_count_q)
		else $error("wide item driven in follow mode");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> black_count <= CNT_W'(SENSOR_LANES))
		else $error("black count exceeds lane count");

endmodule
